// ===== hdl/pcx_pkg.sv =====
// pcx_pkg: request types, action and register codes, and the chaining
// functions of the packet chain xor codec
// no dependencies
package pcx_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_PULL   = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_CODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_KEY   = 8'd1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       first;
        logic [7:0] random_key;
    } pcx_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       checksum_ok;
        logic       error;
    } pcx_out_t;

    // encode one byte: returns {plain, wire}
    function automatic logic [15:0] chain_enc(
        input logic [7:0] d,
        input logic [7:0] rk,
        input logic [7:0] pp,
        input logic [7:0] key,
        input logic [7:0] pe,
        input logic [7:0] k
    );
        logic [7:0] p;
        logic [7:0] b;
        p = d ^ (rk + pp + k);
        b = p ^ (key + pe + k);
        return {p, b};
    endfunction

    // decode one wire byte: returns {plain, data}
    function automatic logic [15:0] chain_dec(
        input logic [7:0] e,
        input logic [7:0] rk,
        input logic [7:0] pp,
        input logic [7:0] key,
        input logic [7:0] pe,
        input logic [7:0] k
    );
        logic [7:0] p;
        logic [7:0] d;
        p = e ^ (pe + key + k);
        d = p ^ (pp + rk + k);
        return {p, d};
    endfunction

endpackage

// ===== hdl/pcx_ram.sv =====
// pcx_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/packet_chain_xor_codec.sv =====
// packet_chain_xor_codec: packet framer / obfuscator with chained xor, top level
// depends on pcx_pkg (types, codes, chain functions) and pcx_ram (payload store)
//
//  channel   ports                        direction  meaning
//  s_        s_valid s_ready s_item       in         load, pull or decode request
//  m_        m_valid m_ready m_item       out        wire byte, decoded byte or error
//  cfg_      cfg_valid cfg_ready          in         register write (index, data)
//            cfg_index cfg_data
//
//  a payload pull (wire byte 5 and up) issues the store read, then does the chain update in S_READ
//  every other request is finished without a store read; the payload store has one read and one write port
//  s_ready drops while a store read is in flight or the result register is full and not taken
//  aresetn (synchronous) clears counts, chain state and registers; the store needs no clearing
//  cfg writes are always taken
module packet_chain_xor_codec #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pcx_pkg::pcx_in_t                  s_item,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output pcx_pkg::pcx_out_t                 m_item,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);
    import pcx_pkg::*;

    // count holds 0..MAX, emit index 0..MAX+5, store address 0..MAX-1
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int IW = $clog2(MAX_PAYLOAD + 6);
    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int PW = 17;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t          state_reg, state_next;

    // configuration registers
    logic [7:0]      code_reg;
    logic [7:0]      key_reg;

    // encode side
    logic [CW-1:0]   count_reg, count_next;
    logic [7:0]      sum_reg, sum_next;
    logic [IW-1:0]   emit_reg, emit_next;
    logic            pend_last_reg, pend_last_next;

    // shared chain state
    logic [7:0]      rk_reg, rk_next;
    logic [7:0]      pp_reg, pp_next;
    logic [7:0]      pe_reg, pe_next;

    // decode side
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      dchk_reg, dchk_next;
    logic [7:0]      dsum_reg, dsum_next;

    // result register
    logic            m_valid_reg, m_valid_next;
    pcx_out_t        m_item_reg, m_item_next;

    // store ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic            acc;
    logic            res_load;
    pcx_out_t        res;

    // scratch for the request being handled
    logic [CW-1:0]   cnt_base;
    logic [7:0]      sum_base;
    logic [IW-1:0]   i_eff;
    logic [IW-1:0]   pull_end;
    logic [7:0]      rk_eff;
    logic [7:0]      pp_eff;
    logic [7:0]      pe_eff;
    logic [PW-1:0]   pos_eff;
    logic [PW-1:0]   dec_end;
    logic [15:0]     chain;
    logic [7:0]      dsum_new;
    logic [7:0]      dchk_new;
    logic [15:0]     count_wide;

    // accept while idle and the result slot is free or being emptied
    assign s_ready   = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign acc       = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign count_wide = 16'(count_reg);

    pcx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_item.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        emit_next      = emit_reg;
        pend_last_next = pend_last_reg;
        rk_next        = rk_reg;
        pp_next        = pp_reg;
        pe_next        = pe_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        dchk_next      = dchk_reg;
        dsum_next      = dsum_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        res_load  = 1'b0;
        res       = '0;

        // first = 1 restarts the packet for its action
        cnt_base  = s_item.first ? '0 : count_reg;
        sum_base  = s_item.first ? 8'd0 : sum_reg;
        i_eff     = s_item.first ? '0 : emit_reg;
        rk_eff    = s_item.first ? s_item.random_key : rk_reg;
        pp_eff    = s_item.first ? 8'd0 : pp_reg;
        pe_eff    = s_item.first ? 8'd0 : pe_reg;
        pos_eff   = s_item.first ? '0 : pos_reg;

        pull_end  = IW'(count_reg) + IW'(4);
        dec_end   = PW'(len_reg) + PW'(4);
        ram_waddr = cnt_base[AW-1:0];
        ram_raddr = AW'(i_eff - IW'(5));
        chain     = '0;
        dsum_new  = dsum_reg;
        dchk_new  = dchk_reg;

        if (state_reg == S_READ) begin
            // payload byte back from the store: finish the chain step
            chain = chain_enc(ram_rdata, rk_reg, pp_reg, key_reg, pe_reg,
                              8'(emit_reg - IW'(4)));
            pp_next         = chain[15:8];
            pe_next         = chain[7:0];
            res_load        = 1'b1;
            res.out_byte    = chain[7:0];
            res.last        = pend_last_reg;
            state_next      = S_IDLE;
        end else if (acc) begin
            case (s_item.action)
                ACT_LOAD: begin
                    count_next = cnt_base;
                    sum_next   = sum_base;
                    if (cnt_base >= CW'(MAX_PAYLOAD)) begin
                        res_load  = 1'b1;
                        res.error = 1'b1;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = cnt_base + CW'(1);
                        sum_next   = sum_base + s_item.data_byte;
                    end
                end
                ACT_PULL: begin
                    emit_next = i_eff;
                    rk_next   = rk_eff;
                    pp_next   = pp_eff;
                    pe_next   = pe_eff;
                    if (i_eff > pull_end) begin
                        res_load  = 1'b1;
                        res.error = 1'b1;
                    end else begin
                        emit_next = i_eff + IW'(1);
                        res.last  = (i_eff == pull_end);
                        if (i_eff == IW'(0)) begin
                            res_load     = 1'b1;
                            res.out_byte = code_reg;
                        end else if (i_eff == IW'(1)) begin
                            res_load     = 1'b1;
                            res.out_byte = count_wide[7:0];
                        end else if (i_eff == IW'(2)) begin
                            res_load     = 1'b1;
                            res.out_byte = count_wide[15:8];
                        end else if (i_eff == IW'(3)) begin
                            res_load     = 1'b1;
                            res.out_byte = rk_eff;
                        end else if (i_eff == IW'(4)) begin
                            // checksum goes first through the chain
                            chain = chain_enc(sum_reg, rk_eff, pp_eff, key_reg, pe_eff, 8'd1);
                            pp_next      = chain[15:8];
                            pe_next      = chain[7:0];
                            res_load     = 1'b1;
                            res.out_byte = chain[7:0];
                        end else begin
                            // payload byte: read the store, finish next cycle
                            ram_re         = 1'b1;
                            pend_last_next = (i_eff == pull_end);
                            state_next     = S_READ;
                        end
                    end
                end
                ACT_DECODE: begin
                    pos_next = pos_eff;
                    if (pos_eff < PW'(4)) begin
                        // header: code is not checked, length is little endian
                        if (pos_eff == PW'(1)) begin
                            len_next = {8'd0, s_item.data_byte};
                        end else if (pos_eff == PW'(2)) begin
                            len_next = {s_item.data_byte, len_reg[7:0]};
                        end else if (pos_eff == PW'(3)) begin
                            rk_next   = s_item.data_byte;
                            pp_next   = 8'd0;
                            pe_next   = 8'd0;
                            dsum_next = 8'd0;
                        end
                        pos_next = pos_eff + PW'(1);
                    end else if (pos_eff <= dec_end) begin
                        chain = chain_dec(s_item.data_byte, rk_reg, pp_reg, key_reg, pe_reg,
                                          8'(pos_eff - PW'(3)));
                        pp_next = chain[15:8];
                        pe_next = s_item.data_byte;
                        if (pos_eff == PW'(4)) begin
                            dchk_new = chain[7:0];
                        end else begin
                            dsum_new = dsum_reg + chain[7:0];
                        end
                        dchk_next       = dchk_new;
                        dsum_next       = dsum_new;
                        pos_next        = pos_eff + PW'(1);
                        res_load        = 1'b1;
                        res.out_byte    = chain[7:0];
                        res.last        = (pos_eff == dec_end);
                        res.checksum_ok = (pos_eff == dec_end) && (dsum_new == dchk_new);
                    end
                end
                default: begin
                end
            endcase
        end

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        m_item_next = res_load ? res : m_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            code_reg      <= 8'd0;
            key_reg       <= 8'd0;
            count_reg     <= '0;
            sum_reg       <= 8'd0;
            emit_reg      <= '0;
            pend_last_reg <= 1'b0;
            rk_reg        <= 8'd0;
            pp_reg        <= 8'd0;
            pe_reg        <= 8'd0;
            pos_reg       <= '0;
            len_reg       <= 16'd0;
            dchk_reg      <= 8'd0;
            dsum_reg      <= 8'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            emit_reg      <= emit_next;
            pend_last_reg <= pend_last_next;
            rk_reg        <= rk_next;
            pp_reg        <= pp_next;
            pe_reg        <= pe_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            dchk_reg      <= dchk_next;
            dsum_reg      <= dsum_next;
            m_valid_reg   <= m_valid_next;
            // register writes beyond the list are dropped
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PACKET_CODE) begin
                    code_reg <= cfg_data;
                end else if (cfg_index == CFG_FIXED_KEY) begin
                    key_reg <= cfg_data;
                end
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

`ifndef SYNTHESIS
    // no request is taken while a store read is in flight
    a_no_accept_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !s_ready)
        else $error("request taken during store read");

    // a store read always finishes with a result in the next cycle
    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |=> (state_reg == S_IDLE) && m_valid)
        else $error("store read did not produce a result");

    // a payload pull enters the read state with an empty result slot
    a_read_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !m_valid_reg)
        else $error("result slot busy during store read");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PAYLOAD))
        else $error("payload count beyond capacity");

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.error) |-> (m_item.out_byte == 8'd0) && !m_item.last
                                      && !m_item.checksum_ok)
        else $error("error result with payload bits set");
`endif

endmodule
